### design/unsigned_restoring_divider_core_defines.svh
// Shared assertion macros for the divider core checker.
`ifndef UNSIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH
`define UNSIGNED_RESTORING_DIVIDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define URDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/urdc_pkg.sv
`default_nettype none

package urdc_pkg;

    localparam int URDC_DATA_WIDTH = 32;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } urdc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture operands, clear partial remainder
        logic step;      // decide one quotient bit
        logic out_load;  // move result into the output register
    } urdc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_step; // current step decides quotient bit 0
    } urdc_status_t;

endpackage

`default_nettype wire

### design/urdc_dpath.sv
`default_nettype none

module urdc_dpath
    import urdc_pkg::*;
#(
    parameter int DATA_WIDTH = URDC_DATA_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire urdc_cmd_t             cmd,
    output urdc_status_t               status,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic      [DATA_WIDTH-1:0] quotient,
    output logic      [DATA_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] rem_reg,  rem_next;
    logic [DATA_WIDTH-1:0] work_reg, work_next;  // dividend bits out, quotient bits in
    logic [DATA_WIDTH-1:0] den_reg;
    logic                  den_zero_reg;
    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic [DATA_WIDTH-1:0] quo_out_reg, rem_out_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    assign shifted = {rem_reg, work_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        cnt_next  = cnt_reg;
        if (cmd.load)
        begin
            rem_next  = '0;
            work_next = dividend;
            cnt_next  = CNT_W'(DATA_WIDTH - 1);
        end
        else if (cmd.step)
        begin
            rem_next  = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            work_next = {work_reg[DATA_WIDTH-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
        if (cmd.load)
        begin
            den_reg      <= divisor;
            den_zero_reg <= (divisor == '0);
        end
        if (cmd.out_load)
        begin
            // zero divisor reports zero quotient and remainder
            quo_out_reg <= den_zero_reg ? '0 : work_reg;
            rem_out_reg <= den_zero_reg ? '0 : rem_reg;
        end
    end

    assign status.last_step = (cnt_reg == '0);
    assign quotient         = quo_out_reg;
    assign remainder        = rem_out_reg;

endmodule

`default_nettype wire

### design/urdc_ctrl.sv
`default_nettype none

module urdc_ctrl
    import urdc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire urdc_status_t status,
    output urdc_cmd_t         cmd
);

    urdc_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### design/unsigned_restoring_divider_core.sv
// Unsigned radix-2 restoring divider.
// Input stream (s_*): one request carries dividend and divisor in s_tdata.
// Output stream (m_*): one result carries quotient and remainder in m_tdata.
// A zero divisor gives quotient 0 and remainder 0.
// A request is captured in the idle state; in the run state the shared
// subtract/compare unit then decides one quotient bit per cycle; the finish
// state moves the result into the output register once that register is
// free, and m_tvalid is driven from a register set in that same step.
// s_tready is high only while the unit is idle; a finished result waits
// in the output register, so the next request is taken while it waits.
// When the receiver stalls and the output register is still full, the
// next result holds in the datapath until the register drains; s_tready
// stays low meanwhile.
// Reset (rst_n low, asynchronous) drops any request in flight and any
// waiting result; the block returns idle with s_tready high.
`default_nettype none

module unsigned_restoring_divider_core
    import urdc_pkg::*;
#(
    parameter int  DATA_WIDTH = URDC_DATA_WIDTH,
    localparam int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // dividend, divisor, zero pad
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [TDATA_W-1:0] m_tdata    // quotient, remainder, zero pad
);

    urdc_cmd_t             cmd;
    urdc_status_t          status;
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;

    urdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    urdc_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .dividend  (s_tdata[DATA_WIDTH-1:0]),
        .divisor   (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // pack result, zero-fill to whole bytes
    assign m_tdata = TDATA_W'({remainder, quotient});

endmodule

`default_nettype wire

### design/urdc_checker.sv
`default_nettype none
`include "unsigned_restoring_divider_core_defines.svh"

module urdc_checker
    import urdc_pkg::*;
#(
    parameter int  DATA_WIDTH = URDC_DATA_WIDTH,
    localparam int TDATA_W    = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata
);

    logic in_hs;
    logic stall;

    assign in_hs = s_tvalid && s_tready;
    assign stall = m_tvalid && !m_tready;

    `URDC_ASSERT_NXT(a_out_hold, clk, rst_n, stall, m_tvalid)
    `URDC_ASSERT_NXT(a_out_stable, clk, rst_n, stall, $stable(m_tdata))
    `URDC_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_hs, !s_tready)
    `URDC_ASSERT_IMP(a_busy_span, clk, rst_n, in_hs, ##(DATA_WIDTH + 1) !s_tready)
    `URDC_ASSERT_IMP(a_result_due, clk, rst_n, in_hs, ##(DATA_WIDTH + 2) m_tvalid)

endmodule

bind unsigned_restoring_divider_core urdc_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_urdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
